// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the polygon clipper.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define PCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pcc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcc_pkg
// Types, sizes and helpers shared by the convex polygon clipper.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int MAX_SUBJECT = 16;
    localparam int MAX_CLIP    = 16;
    localparam int MAX_WORK    = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PROJ_SHIFT  = 2;

    localparam int WQ_DEPTH = 2 * MAX_WORK;
    localparam int WQ_CW    = $clog2(WQ_DEPTH + 1);
    localparam int CQ_CW    = $clog2(MAX_CLIP + 1);
    localparam int SUB_CW   = $clog2(MAX_SUBJECT + 1);
    localparam int WORK_CW  = $clog2(MAX_WORK + 1);
    localparam int DIV_CW   = $clog2(FRAC_BITS + 1);

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int DX_W    = DIFF_W - PROJ_SHIFT;
    localparam int SNX_W   = DIFF_W + 1 - PROJ_SHIFT;
    localparam int SNY_W   = DIFF_W - PROJ_SHIFT;
    localparam int M1_W    = DX_W + SNX_W;
    localparam int M2_W    = DX_W + SNY_W;
    localparam int PROJ_W  = 64;
    localparam int MAG_W   = PROJ_W + 1;
    localparam int REM_W   = MAG_W + 1;
    localparam int Q_W     = FRAC_BITS + 1;
    localparam int XP_W    = DIFF_W + Q_W + 1;
    localparam int LIM_W   = 16;

    localparam logic KIND_SUBJECT = 1'b0;
    localparam logic KIND_CLIP    = 1'b1;

    typedef enum logic [0:0] {
        CFG_INSIDE_SIDE = 1'b0,
        CFG_DEGEN_LIMIT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_vtx;

    typedef struct packed {
        logic clear;
        logic pop;
        logic push;
    } t_q_ctl;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_EDGE,
        S_CHECK,
        S_PA,
        S_PB,
        S_PC,
        S_POP,
        S_DECIDE,
        S_DIV,
        S_XMUL,
        S_XADD,
        S_PUSHCUR,
        S_NEXT,
        S_EMPTY,
        S_EMIT_LOAD,
        S_EMIT_WAIT
    } t_state;

    function automatic logic [MAG_W-1:0] mag_w(input logic signed [MAG_W-1:0] v);
        return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

endpackage

// ===== design/pcc_vcell.sv =====
// ----------------------------------------------------------------------------
// pcc_vcell
// One vertex cell of a store chain: load a new vertex or take the neighbor's.
// ----------------------------------------------------------------------------
module pcc_vcell import pcc_pkg::*; (
    input  logic i_clk,
    input  logic i_shift,
    input  logic i_load,
    input  t_vtx i_load_vtx,
    input  t_vtx i_next_vtx,
    output t_vtx o_vtx
);

    t_vtx r_vtx;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vtx <= i_load_vtx;
        end else if (i_shift) begin
            r_vtx <= i_next_vtx;
        end
    end

    assign o_vtx = r_vtx;

endmodule

// ===== design/pcc_work_q.sv =====
// ----------------------------------------------------------------------------
// pcc_work_q
// Working vertex queue: a chain of cells, pop at cell 0, push at the fill mark.
// ----------------------------------------------------------------------------
module pcc_work_q import pcc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_q_ctl i_ctl,
    input  t_vtx   i_push_vtx,
    output t_vtx   o_head
);

    logic [WQ_CW-1:0] r_count;
    logic [WQ_CW-1:0] n_count;
    logic [WQ_CW-1:0] base_c;
    logic [WQ_CW-1:0] wr_c;
    t_vtx             cell_q [WQ_DEPTH];

    assign base_c  = i_ctl.clear ? '0 : r_count;
    assign wr_c    = base_c - WQ_CW'(i_ctl.pop);
    assign n_count = wr_c + WQ_CW'(i_ctl.push);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    for (genvar k = 0; k < WQ_DEPTH; k++) begin : g_cell
        t_vtx next_c;
        if (k == WQ_DEPTH - 1) begin : g_end
            assign next_c = cell_q[k];
        end else begin : g_mid
            assign next_c = cell_q[k+1];
        end
        pcc_vcell u_cell (
            .i_clk      (i_clk),
            .i_shift    (i_ctl.pop),
            .i_load     (i_ctl.push && (wr_c == WQ_CW'(k))),
            .i_load_vtx (i_push_vtx),
            .i_next_vtx (next_c),
            .o_vtx      (cell_q[k])
        );
    end

    assign o_head = cell_q[0];

endmodule

// ===== design/pcc_clip_q.sv =====
// ----------------------------------------------------------------------------
// pcc_clip_q
// Clip vertex chain: one edge start leaves at cell 0 per edge, cell 1 is next.
// ----------------------------------------------------------------------------
module pcc_clip_q import pcc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_q_ctl i_ctl,
    input  t_vtx   i_push_vtx,
    output t_vtx   o_head,
    output t_vtx   o_head1
);

    logic [CQ_CW-1:0] r_count;
    logic [CQ_CW-1:0] base_c;
    logic [CQ_CW-1:0] wr_c;
    t_vtx             cell_q [MAX_CLIP];

    assign base_c = i_ctl.clear ? '0 : r_count;
    assign wr_c   = base_c - CQ_CW'(i_ctl.pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= wr_c + CQ_CW'(i_ctl.push);
        end
    end

    for (genvar k = 0; k < MAX_CLIP; k++) begin : g_cell
        t_vtx next_c;
        if (k == MAX_CLIP - 1) begin : g_end
            assign next_c = cell_q[k];
        end else begin : g_mid
            assign next_c = cell_q[k+1];
        end
        pcc_vcell u_cell (
            .i_clk      (i_clk),
            .i_shift    (i_ctl.pop),
            .i_load     (i_ctl.push && (wr_c == CQ_CW'(k))),
            .i_load_vtx (i_push_vtx),
            .i_next_vtx (next_c),
            .o_vtx      (cell_q[k])
        );
    end

    assign o_head  = cell_q[0];
    assign o_head1 = cell_q[1];

endmodule

// ===== design/pcc_frac_div.sv =====
// ----------------------------------------------------------------------------
// pcc_frac_div
// Restoring fraction divider: num/den as an unsigned fraction, one bit a cycle.
// ----------------------------------------------------------------------------
module pcc_frac_div import pcc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_num,
    input  logic [MAG_W-1:0] i_den,
    output logic             o_done,
    output logic [Q_W-1:0]   o_q
);

    logic              r_busy;
    logic [DIV_CW-1:0] r_cnt;
    logic [REM_W-1:0]  r_rem;
    logic [MAG_W-1:0]  r_den;
    logic [Q_W-1:0]    r_q;
    logic [REM_W-1:0]  two_c;
    logic              ge_c;

    assign two_c  = {r_rem[REM_W-2:0], 1'b0};
    assign ge_c   = two_c >= {1'b0, r_den};
    assign o_done = r_busy && (r_cnt == '0);
    assign o_q    = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= (i_num >= i_den) ? '0 : DIV_CW'(FRAC_BITS);
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_q   <= (i_num >= i_den) ? Q_W'(1) << FRAC_BITS : '0;
        end else if (r_busy && (r_cnt != '0)) begin
            r_rem <= ge_c ? two_c - {1'b0, r_den} : two_c;
            r_q   <= {r_q[Q_W-2:0], ge_c};
        end
    end

endmodule

// ===== design/polygon_clip_convex.sv =====
// ----------------------------------------------------------------------------
// polygon_clip_convex
// Sutherland-Hodgman clipper of a subject polygon against a convex clip polygon.
// ----------------------------------------------------------------------------
// Load words one per cycle: subject vertices (kind 0, up to 16, more are
// dropped and flagged), then clip vertices (kind 1, up to 16). The clip word
// with final_vertex set starts a run; the input is stalled until the last
// result word is taken. Each clip edge has a setup step, then, for each source
// vertex, a pop, a projection and a decision, and for each edge crossing a
// restoring divider with 16 fraction bits plus a multiply and add. Each result
// word is then loaded from the working queue and offered until it is taken.
// Vertices live in chains of cells: a 64-cell working queue (source vertices
// leave at the head, clipped vertices join at the fill mark) and a 16-cell
// clip chain that gives up one edge start per edge. Results carry the run's
// overflow flag; a fully clipped polygon gives one word with empty_result set.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module polygon_clip_convex import pcc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input vertex channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_kind,
    input  logic signed [COORD_W-1:0] i_vertex_x,
    input  logic signed [COORD_W-1:0] i_vertex_y,
    input  logic                      i_final_vertex,
    // result channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [COORD_W-1:0] o_out_x,
    output logic signed [COORD_W-1:0] o_out_y,
    output logic                      o_last_out,
    output logic                      o_empty_result,
    output logic                      o_overflow,
    // configuration write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [0:0]                i_cfg_index,
    input  logic [LIM_W-1:0]          i_cfg_data
);

    t_state r_state, n_state;

    // configuration
    logic             r_inside_side;
    logic [LIM_W-1:0] r_degen_limit;

    // control state
    logic [SUB_CW-1:0]  r_sub_cnt;
    logic               r_sub_closed;
    logic [CQ_CW-1:0]   r_clip_cnt;
    logic               r_ovf;
    logic [CQ_CW-1:0]   r_edges_left;
    logic [WORK_CW-1:0] r_src_left;
    logic [WORK_CW-1:0] r_dn;
    logic               r_for_last;

    // datapath
    t_vtx                     r_clip0, r_tail, r_s, r_cur, r_last;
    logic signed [DIFF_W-1:0] r_ex, r_ey;
    logic signed [SNX_W-1:0]  r_snx;
    logic signed [SNY_W-1:0]  r_sny;
    logic signed [DX_W-1:0]   r_dx, r_dy;
    logic signed [M1_W-1:0]   r_m1;
    logic signed [M2_W-1:0]   r_m2;
    logic signed [PROJ_W-1:0] r_cp, r_lp;
    logic                     r_lin, r_cin;
    logic signed [XP_W-1:0]   r_xp, r_yp;
    logic signed [COORD_W-1:0] r_out_x, r_out_y;
    logic                     r_out_last, r_out_empty;

    // combinational
    logic                     in_acc_c, out_acc_c;
    logic [SUB_CW-1:0]        sub_base_c;
    logic                     sub_room_c;
    t_vtx                     in_vtx_c, cq_head, cq_head1, wq_head, edge_end_c;
    t_q_ctl                   wq_ctl, cq_ctl;
    t_vtx                     wq_push_vtx;
    logic                     stage_push_c, stage_room_c;
    t_vtx                     cross_c;
    logic                     degen_c;
    logic signed [DIFF_W:0]   neg_ey_c;
    logic signed [DIFF_W-1:0] ddx_c, ddy_c, xdx_c, xdy_c;
    logic signed [PROJ_W-1:0] sum_c;
    logic                     sum_in_c, cp_in_c;
    logic                     div_start, div_done;
    logic [Q_W-1:0]           div_q;
    logic [MAG_W-1:0]         div_num_c, div_den_c;
    logic signed [MAG_W-1:0]  pdiff_c;

    function automatic logic is_inside(input logic side, input logic signed [PROJ_W-1:0] p);
        return side ? (p >= 0) : (p <= 0);
    endfunction

    assign in_acc_c   = i_valid && !o_stall;
    assign out_acc_c  = o_valid && !i_stall;
    assign sub_base_c = r_sub_closed ? '0 : r_sub_cnt;
    assign sub_room_c = sub_base_c < SUB_CW'(MAX_SUBJECT);
    assign in_vtx_c   = '{x: i_vertex_x, y: i_vertex_y};

    // edge geometry
    assign edge_end_c = (r_edges_left == CQ_CW'(1)) ? r_clip0 : cq_head1;
    assign degen_c = (mag_w(MAG_W'(r_ex)) <= MAG_W'(r_degen_limit))
                  && (mag_w(MAG_W'(r_ey)) <= MAG_W'(r_degen_limit));
    assign neg_ey_c = -(DIFF_W+1)'(r_ey);

    // projection of r_cur onto the edge normal
    assign ddx_c = DIFF_W'(r_cur.x) - DIFF_W'(r_s.x);
    assign ddy_c = DIFF_W'(r_cur.y) - DIFF_W'(r_s.y);
    assign sum_c = PROJ_W'(r_m1) + PROJ_W'(r_m2);
    assign sum_in_c = is_inside(r_inside_side, sum_c);
    assign cp_in_c  = is_inside(r_inside_side, r_cp);

    // crossing point
    assign pdiff_c   = MAG_W'(r_cp) - MAG_W'(r_lp);
    assign div_num_c = mag_w(MAG_W'(r_lp));
    assign div_den_c = mag_w(pdiff_c);
    assign xdx_c = DIFF_W'(r_cur.x) - DIFF_W'(r_last.x);
    assign xdy_c = DIFF_W'(r_cur.y) - DIFF_W'(r_last.y);
    assign cross_c.x = r_last.x + r_xp[FRAC_BITS+COORD_W-1:FRAC_BITS];
    assign cross_c.y = r_last.y + r_yp[FRAC_BITS+COORD_W-1:FRAC_BITS];

    assign stage_room_c = r_dn < WORK_CW'(MAX_WORK);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc_c && (i_kind == KIND_CLIP) && i_final_vertex) begin
                    n_state = S_START;
                end
            end
            S_START:   n_state = (r_sub_cnt == '0) ? S_EMPTY : S_EDGE;
            S_EDGE:    n_state = (r_edges_left == '0) ? S_EMIT_LOAD : S_CHECK;
            S_CHECK:   n_state = degen_c ? S_EDGE : S_PA;
            S_PA:      n_state = S_PB;
            S_PB:      n_state = S_PC;
            S_PC:      n_state = r_for_last ? S_POP : S_DECIDE;
            S_POP:     n_state = S_PA;
            S_DECIDE: begin
                if (cp_in_c != r_lin) begin
                    n_state = S_DIV;
                end else if (cp_in_c) begin
                    n_state = S_PUSHCUR;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_DIV:     n_state = div_done ? S_XMUL : S_DIV;
            S_XMUL:    n_state = S_XADD;
            S_XADD:    n_state = r_cin ? S_PUSHCUR : S_NEXT;
            S_PUSHCUR: n_state = S_NEXT;
            S_NEXT: begin
                if (r_src_left != '0) begin
                    n_state = S_POP;
                end else if (r_dn == '0) begin
                    n_state = S_EMPTY;
                end else begin
                    n_state = S_EDGE;
                end
            end
            S_EMPTY:     n_state = S_EMIT_WAIT;
            S_EMIT_LOAD: n_state = S_EMIT_WAIT;
            S_EMIT_WAIT: begin
                if (!i_stall) begin
                    n_state = r_out_last ? S_IDLE : S_EMIT_LOAD;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // outputs and store control
    always_comb begin
        wq_ctl       = '0;
        cq_ctl       = '0;
        wq_push_vtx  = in_vtx_c;
        stage_push_c = 1'b0;
        div_start    = 1'b0;
        o_stall      = (r_state != S_IDLE);
        o_valid      = (r_state == S_EMIT_WAIT);
        unique case (r_state)
            S_IDLE: begin
                if (in_acc_c && (i_kind == KIND_SUBJECT)) begin
                    wq_ctl.clear = r_sub_closed;
                    wq_ctl.push  = sub_room_c;
                end
                if (in_acc_c && (i_kind == KIND_CLIP)) begin
                    cq_ctl.push = r_clip_cnt < CQ_CW'(MAX_CLIP);
                end
            end
            S_CHECK: begin
                cq_ctl.pop = degen_c;
            end
            S_POP, S_EMIT_LOAD: begin
                wq_ctl.pop = 1'b1;
            end
            S_DECIDE: begin
                div_start = (cp_in_c != r_lin);
            end
            S_XADD: begin
                wq_push_vtx  = cross_c;
                stage_push_c = 1'b1;
                wq_ctl.push  = stage_room_c;
            end
            S_PUSHCUR: begin
                wq_push_vtx  = r_cur;
                stage_push_c = 1'b1;
                wq_ctl.push  = stage_room_c;
            end
            S_NEXT: begin
                cq_ctl.pop = (r_src_left == '0) && (r_dn != '0);
            end
            S_EMIT_WAIT: begin
                wq_ctl.clear = out_acc_c && r_out_last;
                cq_ctl.clear = out_acc_c && r_out_last;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_inside_side <= 1'b0;
            r_degen_limit <= '0;
            r_sub_cnt     <= '0;
            r_sub_closed  <= 1'b0;
            r_clip_cnt    <= '0;
            r_ovf         <= 1'b0;
            r_edges_left  <= '0;
            r_src_left    <= '0;
            r_dn          <= '0;
            r_for_last    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_INSIDE_SIDE: r_inside_side <= i_cfg_data[0];
                    CFG_DEGEN_LIMIT: r_degen_limit <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (stage_push_c) begin
                if (stage_room_c) begin
                    r_dn <= r_dn + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc_c && (i_kind == KIND_SUBJECT)) begin
                        // a new subject after a closed one starts over
                        r_sub_cnt    <= sub_room_c ? sub_base_c + 1'b1 : sub_base_c;
                        r_sub_closed <= i_final_vertex;
                        if (!sub_room_c) begin
                            r_ovf <= 1'b1;
                        end
                    end
                    if (in_acc_c && (i_kind == KIND_CLIP)) begin
                        if (r_clip_cnt < CQ_CW'(MAX_CLIP)) begin
                            r_clip_cnt <= r_clip_cnt + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                S_START: begin
                    r_src_left   <= WORK_CW'(r_sub_cnt);
                    r_edges_left <= r_clip_cnt;
                end
                S_CHECK: begin
                    if (degen_c) begin
                        r_edges_left <= r_edges_left - 1'b1;
                    end else begin
                        r_dn       <= '0;
                        r_for_last <= 1'b1;
                    end
                end
                S_POP: begin
                    r_src_left <= r_src_left - 1'b1;
                    r_for_last <= 1'b0;
                end
                S_NEXT: begin
                    if ((r_src_left == '0) && (r_dn != '0)) begin
                        r_src_left   <= r_dn;
                        r_edges_left <= r_edges_left - 1'b1;
                    end
                end
                S_EMIT_LOAD: begin
                    r_src_left <= r_src_left - 1'b1;
                end
                S_EMIT_WAIT: begin
                    if (out_acc_c && r_out_last) begin
                        r_sub_cnt    <= '0;
                        r_sub_closed <= 1'b0;
                        r_clip_cnt   <= '0;
                        r_ovf        <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (wq_ctl.push) begin
            r_tail <= wq_push_vtx;
        end
        if (cq_ctl.push && (r_clip_cnt == '0)) begin
            r_clip0 <= in_vtx_c;
        end
        unique case (r_state)
            S_EDGE: begin
                r_s  <= cq_head;
                r_ex <= DIFF_W'(edge_end_c.x) - DIFF_W'(cq_head.x);
                r_ey <= DIFF_W'(edge_end_c.y) - DIFF_W'(cq_head.y);
            end
            S_CHECK: begin
                // normal (-ey, ex), floored by the projection shift
                r_snx  <= neg_ey_c[DIFF_W:PROJ_SHIFT];
                r_sny  <= r_ex[DIFF_W-1:PROJ_SHIFT];
                r_cur  <= r_tail;
                r_last <= r_tail;
            end
            S_PA: begin
                r_dx <= ddx_c[DIFF_W-1:PROJ_SHIFT];
                r_dy <= ddy_c[DIFF_W-1:PROJ_SHIFT];
            end
            S_PB: begin
                r_m1 <= M1_W'(r_dx) * M1_W'(r_snx);
                r_m2 <= M2_W'(r_dy) * M2_W'(r_sny);
            end
            S_PC: begin
                if (r_for_last) begin
                    r_lp  <= sum_c;
                    r_lin <= sum_in_c;
                end else begin
                    r_cp <= sum_c;
                end
            end
            S_POP: begin
                r_cur <= wq_head;
            end
            S_DECIDE: begin
                r_cin <= cp_in_c;
            end
            S_XMUL: begin
                r_xp <= XP_W'(xdx_c) * XP_W'($signed({1'b0, div_q}));
                r_yp <= XP_W'(xdy_c) * XP_W'($signed({1'b0, div_q}));
            end
            S_NEXT: begin
                r_last <= r_cur;
                r_lp   <= r_cp;
                r_lin  <= r_cin;
            end
            S_EMPTY: begin
                r_out_x     <= '0;
                r_out_y     <= '0;
                r_out_last  <= 1'b1;
                r_out_empty <= 1'b1;
            end
            S_EMIT_LOAD: begin
                r_out_x     <= wq_head.x;
                r_out_y     <= wq_head.y;
                r_out_last  <= (r_src_left == WORK_CW'(1));
                r_out_empty <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    pcc_work_q u_work_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (wq_ctl),
        .i_push_vtx (wq_push_vtx),
        .o_head     (wq_head)
    );

    pcc_clip_q u_clip_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (cq_ctl),
        .i_push_vtx (in_vtx_c),
        .o_head     (cq_head),
        .o_head1    (cq_head1)
    );

    pcc_frac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num_c),
        .i_den   (div_den_c),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_out_x        = r_out_x;
    assign o_out_y        = r_out_y;
    assign o_last_out     = r_out_last;
    assign o_empty_result = r_out_empty;
    assign o_overflow     = r_ovf;

    `PCC_ASSERT_IMPL(a_no_input_while_emit, i_clk, i_rst_n, o_valid, o_stall, "input open during emit")
    `PCC_ASSERT_IMPL(a_empty_is_last, i_clk, i_rst_n, o_valid && o_empty_result, o_last_out, "empty word not last")
    `PCC_ASSERT_IMPL(a_stage_cap, i_clk, i_rst_n, 1'b1, r_dn <= WORK_CW'(MAX_WORK), "stage count over capacity")
    `PCC_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, out_acc_c && o_last_out, !o_valid && !o_stall, "no return to idle")

endmodule
